// ===== hdl/cdtpf_pkg.sv =====
// Shared types, constants and CRC helpers for the CD-Text pack framer.
// No dependencies; imported by the front end, the back end and the top level.
`default_nettype none

package cdtpf_pkg;

  localparam int PAYLOAD_BYTES = 12;
  localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
  localparam int MSG_W         = PAYLOAD_W + 32;
  localparam int FILL_W        = $clog2(PAYLOAD_BYTES);
  localparam int TYPE_COUNT    = 16;

  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [7:0]  SIZE_KIND       = 8'h8F;
  localparam logic [3:0]  TEXT_GROUP      = 4'h8;
  localparam logic [3:0]  POS_CAP         = 4'd15;
  localparam logic [7:0]  SIZE_PACK_COUNT = 8'd3;
  localparam logic [7:0]  SIZE_PACK_ONE   = 8'd1;
  localparam logic [7:0]  LANGUAGE_RESET  = 8'd9;
  localparam logic [6:0]  LAST_TRACK_RESET = 7'd1;

  typedef enum logic [1:0] {
    REG_CHARSET    = 2'd0,
    REG_LANGUAGE   = 2'd1,
    REG_LAST_TRACK = 2'd2
  } cfg_reg_e;

  // Front to back: one text pack to send, or a finish request.
  typedef struct packed {
    logic                 finish;
    logic                 flush;
    logic [7:0]           kind;
    logic [6:0]           track;
    logic [3:0]           pos;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [6:0]  track;
    logic [7:0]  seq;
    logic [3:0]  pos;
    logic [63:0] head;
    logic [31:0] tail;
    logic [15:0] crc;
    logic        last;
  } pack_t;

  // Column i is the CRC of a message with only bit i set (bit 0 sent last).
  function automatic logic [MSG_W-1:0][15:0] crc_cols_f();
    logic [MSG_W-1:0][15:0] cols;
    logic [15:0]            c;
    c = CRC_POLY;
    for (int i = 0; i < MSG_W; i++) begin
      cols[i] = c;
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return cols;
  endfunction

  localparam logic [MSG_W-1:0][15:0] CRC_COLS = crc_cols_f();

  // CRC is linear with a zero start value: XOR the columns of the set bits, then invert.
  function automatic logic [15:0] crc16_inv_f(logic [MSG_W-1:0] msg);
    logic [15:0] c;
    c = '0;
    for (int i = 0; i < MSG_W; i++) begin
      if (msg[i]) begin
        c = c ^ CRC_COLS[i];
      end
    end
    return ~c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cdtpf_fifo.sv =====
// Small first-word-fall-through queue of registers, generic in item type.
// Depends on nothing; used for the command queue and the result queue.
`default_nettype none

module cdtpf_fifo #(
  parameter type item_t = logic,
  parameter int  Depth  = 2
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  item_t data_i,
  output logic  full_o,
  input  wire   pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  item_t         mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cdtpf_front.sv =====
// Front end: gathers character bytes into 12-byte payloads and tracks
// string positions; issues pack and finish commands. Uses cdtpf_pkg.
`default_nettype none

module cdtpf_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                accept_i,
  input  wire                op_i,
  input  wire  [7:0]         text_type_i,
  input  wire  [6:0]         track_number_i,
  input  wire  [7:0]         char_byte_i,
  output logic               cmd_push_o,
  output cdtpf_pkg::cmd_t    cmd_o
);

  import cdtpf_pkg::*;

  localparam logic [FILL_W-1:0] LAST_SLOT = FILL_W'(PAYLOAD_BYTES - 1);

  logic [7:0]        buf_q [PAYLOAD_BYTES];
  logic [FILL_W-1:0] fill_q;
  logic [7:0]        held_type_q;
  logic [6:0]        held_track_q;
  logic [3:0]        held_pos_q;
  logic [7:0]        offset_q;

  logic              is_text, is_finish, slot_last;
  logic [3:0]        cur_pos;
  logic [PAYLOAD_W-1:0] full_payload, part_payload;

  assign is_text   = accept_i && !op_i;
  assign is_finish = accept_i && op_i;
  assign slot_last = (fill_q == LAST_SLOT);
  assign cur_pos   = (offset_q > 8'(POS_CAP)) ? POS_CAP : offset_q[3:0];

  always_comb begin
    full_payload = '0;
    part_payload = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      full_payload[PAYLOAD_W-1-8*i -: 8] =
        (i == PAYLOAD_BYTES - 1) ? char_byte_i : buf_q[i];
      part_payload[PAYLOAD_W-1-8*i -: 8] =
        (FILL_W'(i) < fill_q) ? buf_q[i] : 8'd0;
    end
  end

  always_comb begin
    cmd_push_o    = is_finish || (is_text && slot_last);
    cmd_o.finish  = op_i;
    cmd_o.flush   = (fill_q != '0);
    cmd_o.kind    = held_type_q;
    cmd_o.track   = held_track_q;
    cmd_o.pos     = held_pos_q;
    cmd_o.payload = op_i ? part_payload : full_payload;
  end

  always_ff @(posedge clk_i) begin
    if (is_text) begin
      buf_q[fill_q] <= char_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      held_type_q  <= '0;
      held_track_q <= '0;
      held_pos_q   <= '0;
      offset_q     <= '0;
    end else if (is_finish) begin
      fill_q   <= '0;
      offset_q <= '0;
    end else if (is_text) begin
      if (fill_q == '0) begin
        held_type_q  <= text_type_i;
        held_track_q <= track_number_i;
        held_pos_q   <= cur_pos;
      end
      fill_q <= slot_last ? '0 : fill_q + FILL_W'(1);
      if (char_byte_i == 8'd0) begin
        offset_q <= '0;
      end else if (offset_q != 8'hFF) begin
        offset_q <= offset_q + 8'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cdtpf_back.sv =====
// Back end: numbers packs, keeps per-type pack counts, builds size packs
// and computes the pack CRC. Uses cdtpf_pkg.
`default_nettype none

module cdtpf_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cmd_valid_i,
  input  cdtpf_pkg::cmd_t    cmd_i,
  output logic               cmd_pop_o,
  input  wire                out_full_i,
  output logic               out_push_o,
  output cdtpf_pkg::pack_t   pack_o,
  input  wire  [7:0]         charset_i,
  input  wire  [7:0]         language_i,
  input  wire  [6:0]         last_track_i
);

  import cdtpf_pkg::*;

  typedef enum logic [1:0] {
    PH_FLUSH,
    PH_SIZE0,
    PH_SIZE1,
    PH_SIZE2
  } ph_e;

  ph_e         ph_q, ph_eff, ph_nxt;
  logic [7:0]  seq_q;
  logic [7:0]  cnt_q [TYPE_COUNT];

  logic                 go, text_pack;
  logic [7:0]           kind;
  logic [6:0]           track;
  logic [3:0]           pos;
  logic [PAYLOAD_W-1:0] payload;
  logic                 last;

  assign go = cmd_valid_i && !out_full_i;

  always_comb begin
    ph_eff = (cmd_i.finish && ph_q == PH_FLUSH && !cmd_i.flush) ? PH_SIZE0 : ph_q;
    text_pack = 1'b0;
    kind      = SIZE_KIND;
    track     = '0;
    pos       = '0;
    payload   = '0;
    last      = 1'b0;
    ph_nxt    = ph_q;
    unique case (ph_eff)
      PH_FLUSH: begin
        text_pack = 1'b1;
        kind      = cmd_i.kind;
        track     = cmd_i.track;
        pos       = cmd_i.pos;
        payload   = cmd_i.payload;
        last      = !cmd_i.finish;
        ph_nxt    = cmd_i.finish ? PH_SIZE0 : PH_FLUSH;
      end
      PH_SIZE0: begin
        track   = 7'd0;
        payload = {charset_i, SIZE_PACK_ONE, {1'b0, last_track_i}, SIZE_PACK_COUNT,
                   cnt_q[0], cnt_q[1], cnt_q[2], cnt_q[3],
                   cnt_q[4], cnt_q[5], cnt_q[6], cnt_q[7]};
        ph_nxt  = PH_SIZE1;
      end
      PH_SIZE1: begin
        // Sequence register already holds s+1 here; the last pack is s+2.
        track   = 7'd1;
        payload = {cnt_q[8], cnt_q[9], cnt_q[10], cnt_q[11],
                   cnt_q[12], cnt_q[13], cnt_q[14],
                   8'(cnt_q[15] + SIZE_PACK_COUNT),
                   8'(seq_q + 8'd1), 24'd0};
        ph_nxt  = PH_SIZE2;
      end
      PH_SIZE2: begin
        track   = 7'd2;
        payload = {32'd0, language_i, 56'd0};
        last    = 1'b1;
        ph_nxt  = PH_FLUSH;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_push_o    = go;
    cmd_pop_o     = go && (!cmd_i.finish || ph_eff == PH_SIZE2);
    pack_o.kind   = kind;
    pack_o.track  = track;
    pack_o.seq    = seq_q;
    pack_o.pos    = pos;
    pack_o.head   = payload[PAYLOAD_W-1 -: 64];
    pack_o.tail   = payload[31:0];
    pack_o.last   = last;
    pack_o.crc    = crc16_inv_f({kind, 1'b0, track, seq_q, 4'd0, pos, payload});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_FLUSH;
      seq_q <= '0;
      for (int i = 0; i < TYPE_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (go) begin
      ph_q <= ph_nxt;
      if (ph_eff == PH_SIZE2) begin
        // Finish done: clear numbering and counts for the next disc.
        seq_q <= '0;
        for (int i = 0; i < TYPE_COUNT; i++) begin
          cnt_q[i] <= '0;
        end
      end else begin
        seq_q <= seq_q + 8'd1;
        if (text_pack && kind[7:4] == TEXT_GROUP) begin
          cnt_q[kind[3:0]] <= cnt_q[kind[3:0]] + 8'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cd_text_pack_framer.sv =====
// CD-Text pack framer, top level: configuration registers, front end,
// command queue, back end and result queue. Uses cdtpf_pkg and submodules.
//
// Usage:
//   Input side is a queue write port: present op_i and the tag fields with
//   push high; the transaction happens on a rising edge with full low. A
//   text byte (op_i = 0) fills the current 12-byte payload; the twelfth byte
//   produces one pack. A finish (op_i = 1) flushes a partial payload padded
//   with zeros, then produces the three size packs and clears the framing state.
//   Result side is a queue read port: while empty is low the oldest pack is
//   on the *_o fields; pop high on an edge completes the transaction.
//   run_last_o marks the last pack caused by one input transaction.
//   Throughput: one text byte per cycle while full is low. The back end
//   emits one pack per cycle while the result queue has room, so a finish
//   holds it for its flush and size packs; full rises only when finishes
//   follow each other closely or the receiver stalls. A pack's command is
//   registered in the command queue on the edge that accepts the byte or
//   finish behind it, then the pack is registered in the result queue.
//   If the receiver stalls, the result queue fills, the back end holds, the
//   command queue fills and full rises; nothing is dropped.
//   Reset clears all framing state; charset is 0, language 9, last track 1.
//   Write configuration through cfg_we_i only while the block is idle.
`default_nettype none

module cd_text_pack_framer #(
  parameter int CmdDepth = 2,
  parameter int OutDepth = 2
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write port
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [7:0]  cfg_wdata_i,
  // input queue port
  input  wire         push,
  output logic        full,
  input  wire         op_i,
  input  wire  [7:0]  text_type_i,
  input  wire  [6:0]  track_number_i,
  input  wire  [7:0]  char_byte_i,
  // result queue port
  output logic        empty,
  input  wire         pop,
  output logic [7:0]  pack_kind_o,
  output logic [6:0]  pack_track_o,
  output logic [7:0]  sequence_res_o,
  output logic [3:0]  char_position_o,
  output logic [63:0] payload_head_o,
  output logic [31:0] payload_tail_o,
  output logic [15:0] pack_crc_o,
  output logic        run_last_o
);

  import cdtpf_pkg::*;

  logic [7:0] charset_q, language_q;
  logic [6:0] last_track_q;

  logic  accept;
  logic  cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t  cmd_in, cmd_head;
  logic  out_push, out_full;
  pack_t pack_in, pack_head;

  // Hold configuration; indexes past the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charset_q    <= '0;
      language_q   <= LANGUAGE_RESET;
      last_track_q <= LAST_TRACK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CHARSET:    charset_q    <= cfg_wdata_i;
        REG_LANGUAGE:   language_q   <= cfg_wdata_i;
        REG_LAST_TRACK: last_track_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Accept an item whenever the command queue has room, even for bytes that
  // do not complete a pack.
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  cdtpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_i),
    .text_type_i    (text_type_i),
    .track_number_i (track_number_i),
    .char_byte_i    (char_byte_i),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  cdtpf_fifo #(
    .item_t (cmd_t),
    .Depth  (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  cdtpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!cmd_empty),
    .cmd_i        (cmd_head),
    .cmd_pop_o    (cmd_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .pack_o       (pack_in),
    .charset_i    (charset_q),
    .language_i   (language_q),
    .last_track_i (last_track_q)
  );

  // Result queue parts the back end from a stalling receiver.
  cdtpf_fifo #(
    .item_t (pack_t),
    .Depth  (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (pack_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (pack_head),
    .empty_o (empty)
  );

  assign pack_kind_o     = pack_head.kind;
  assign pack_track_o    = pack_head.track;
  assign sequence_res_o  = pack_head.seq;
  assign char_position_o = pack_head.pos;
  assign payload_head_o  = pack_head.head;
  assign payload_tail_o  = pack_head.tail;
  assign pack_crc_o      = pack_head.crc;
  assign run_last_o      = pack_head.last;

endmodule

`default_nettype wire
